// File: sv/aal5_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the AAL5 cell reassembly checker.
// Depends on nothing; aal5_cell_calc, aal5_out_fifo and the top level import it.
package aal5_pkg;

  localparam int NUM_VC        = 256;
  localparam int TRAILER_BYTES = 8;

  localparam int VC_W    = 8;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // A cell carries 48 payload bytes, split as 16 * 3 for the divider.
  localparam int PAYLOAD_SHIFT = 4;
  localparam int CELL_PAYLOAD  = 3 << PAYLOAD_SHIFT;
  localparam int CELL_ROUND    = CELL_PAYLOAD - 1;
  localparam int SUM_W         = LEN_W + 1;
  localparam int QUART_W       = SUM_W - PAYLOAD_SHIFT;
  localparam int DIV3_SHIFT    = 17;
  localparam int DIV3_RECIP    = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int RECIP_W       = 16;
  localparam int DIV3_PROD_W   = QUART_W + RECIP_W;

  // Only circuits 0..255 can be addressed, so the store never needs more rows.
  localparam int STORE_DEPTH = (NUM_VC < (1 << VC_W)) ? NUM_VC : (1 << VC_W);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int IDX_RECIP   = ((1 << 16) + STORE_DEPTH - 1) / STORE_DEPTH;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic [TOTAL_W-1:0] frames_delivered;
    logic [COUNT_W-1:0] cells_seen;
    logic               frame_ok;
    logic [LEN_W-1:0]   frame_bytes;
    logic [VC_W-1:0]    frame_vc;
  } result_t;

  // Circuit address modulo the store depth, by reciprocal multiplication.
  function automatic logic [IDX_W-1:0] store_index(input logic [VC_W-1:0] vc);
    logic [23:0]    prod;
    logic [VC_W-1:0] quo;
    logic [16:0]    back;
    logic [16:0]    rest;
    prod = {16'b0, vc} * 24'(IDX_RECIP);
    quo  = prod[23:16];
    back = {9'b0, quo} * 17'(STORE_DEPTH);
    rest = {9'b0, vc} - back;
    if (rest >= 17'(STORE_DEPTH)) begin
      rest = rest - 17'(STORE_DEPTH);
    end
    return rest[IDX_W-1:0];
  endfunction

endpackage

// File: sv/aal5_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// A read of the address being written returns the old contents. No dependencies.
module aal5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/aal5_cell_calc.sv
`timescale 1ns / 1ps
// Expected cell count of a frame, ceil((pdu_length + trailer) / 48), registered.
// Depends on aal5_pkg.
module aal5_cell_calc (
  input  logic                          clk,
  input  logic                          en,
  input  logic [aal5_pkg::LEN_W-1:0]    pdu_length,
  output logic [aal5_pkg::COUNT_W-1:0]  expected_r
);
  import aal5_pkg::*;

  logic [SUM_W-1:0]       sum;
  logic [QUART_W-1:0]     quart;
  logic [DIV3_PROD_W-1:0] prod;
  logic [COUNT_W-1:0]     expected_nxt;

  // Divide by 16 with a shift, then by 3 with a reciprocal that is exact for
  // every value below 2^17.
  always_comb begin
    sum          = {1'b0, pdu_length} + SUM_W'(TRAILER_BYTES + CELL_ROUND);
    quart        = sum[SUM_W-1:PAYLOAD_SHIFT];
    prod         = DIV3_PROD_W'(quart) * DIV3_PROD_W'(DIV3_RECIP);
    expected_nxt = prod[DIV3_SHIFT +: COUNT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      expected_r <= expected_nxt;
    end
  end

endmodule

// File: sv/aal5_out_fifo.sv
`timescale 1ns / 1ps
// Small result queue in front of the output channel; lets the pipeline keep
// taking cells while a result waits. Depends on aal5_pkg.
module aal5_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  aal5_pkg::result_t                 push_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output aal5_pkg::result_t                 out_data,
  output logic [aal5_pkg::FIFO_CNT_W-1:0]   count_r
);
  import aal5_pkg::*;

  result_t               entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/aal5_cell_reassembly_checker_top.sv
`timescale 1ns / 1ps
// Top level of the AAL5 cell reassembly checker; depends on aal5_pkg, aal5_ram,
// aal5_cell_calc and aal5_out_fifo.
//
// The block takes one cell per clock and keeps an 11-bit cell count per circuit in
// a single RAM. After reset it clears that RAM row by row with in_tready low. After
// that a cell is accepted in every cycle in which the three-entry result queue has
// room; the rate is set by the one read-modify-write of the count RAM per cell,
// with the previous cell's write forwarded when both hit the same row. A final
// cell's result is registered in the pipeline stage and then in the result queue
// before it is offered on out_tvalid; cells that do not end a frame give no result.
module aal5_cell_reassembly_checker_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] vc_addr, [23:8] pdu_length
  input  logic [aal5_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] frame_vc, [23:8] frame_bytes, [34:24] cells_seen,
  // [66:35] frames_delivered, [71:67] zero
  output logic [aal5_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] frame_ok
  output logic                               out_tuser
);
  import aal5_pkg::*;

  logic                  in_accept;
  logic [VC_W-1:0]       in_vc;
  logic [LEN_W-1:0]      in_len;
  logic [IDX_W-1:0]      in_idx;

  logic                  clr_active_r, clr_active_nxt;
  logic [IDX_W-1:0]      clr_idx_r, clr_idx_nxt;

  logic                  s1_valid_r;
  logic                  s1_last_r;
  logic [VC_W-1:0]       s1_vc_r;
  logic [LEN_W-1:0]      s1_len_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [COUNT_W-1:0]    expected_r;

  logic                  fwd_valid_r;
  logic [IDX_W-1:0]      fwd_idx_r;
  logic [COUNT_W-1:0]    fwd_data_r;

  logic [COUNT_W-1:0]    ram_rdata;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_W-1:0]    ram_wdata;

  logic [COUNT_W-1:0]    cur_count;
  logic [COUNT_W-1:0]    new_count;
  logic [COUNT_W-1:0]    seen;
  logic                  ok;
  logic                  s1_result;
  logic [TOTAL_W-1:0]    total_r, total_nxt;

  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;
  result_t               res;
  result_t               out_res;

  assign in_vc  = in_tdata[VC_W-1:0];
  assign in_len = in_tdata[VC_W +: LEN_W];
  assign in_idx = store_index(in_vc);

  // Room must be reserved for a result still in the pipeline stage.
  assign s1_result = s1_valid_r & s1_last_r;
  assign occupancy = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(s1_result);
  assign in_tready = !clr_active_r && (occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign in_accept = in_tvalid & in_tready;

  // Clearing pass after reset.
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    if (clr_active_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(STORE_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
    end
  end

  aal5_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (STORE_DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  aal5_cell_calc u_cell_calc (
    .clk        (clk),
    .en         (in_accept),
    .pdu_length (in_len),
    .expected_r (expected_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      s1_valid_r  <= in_accept;
      fwd_valid_r <= s1_valid_r;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last_r <= in_tlast;
      s1_vc_r   <= in_vc;
      s1_len_r  <= in_len;
      s1_idx_r  <= in_idx;
    end
    fwd_idx_r  <= s1_idx_r;
    fwd_data_r <= new_count;
  end

  // The RAM returns the old row when the cell just ahead wrote it in the same
  // edge, so that write is taken from the forwarding register instead.
  always_comb begin
    cur_count = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : ram_rdata;
    seen      = (cur_count == COUNT_MAX) ? COUNT_MAX : cur_count + 1'b1;
    ok        = (cur_count != COUNT_MAX) && (seen == expected_r);
    if (s1_last_r) begin
      new_count = '0;
    end else begin
      new_count = seen;
    end
    total_nxt = total_r;
    if (s1_result && ok) begin
      total_nxt = total_r + 1'b1;
    end
  end

  always_comb begin
    ram_we    = clr_active_r | s1_valid_r;
    ram_waddr = clr_active_r ? clr_idx_r : s1_idx_r;
    ram_wdata = clr_active_r ? '0 : new_count;
  end

  always_comb begin
    res.frame_vc         = s1_vc_r;
    res.frame_bytes      = s1_len_r;
    res.frame_ok         = ok;
    res.cells_seen       = seen;
    res.frames_delivered = total_nxt;
  end

  aal5_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_result),
    .push_data (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res),
    .count_r   (fifo_count)
  );

  assign out_tdata = {{(OUT_DATA_W - TOTAL_W - COUNT_W - LEN_W - VC_W){1'b0}},
                      out_res.frames_delivered, out_res.cells_seen,
                      out_res.frame_bytes, out_res.frame_vc};
  assign out_tuser = out_res.frame_ok;

  // A frame closed on a row cannot leak its old count into the next cell there.
  a_fwd_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) ##1 (s1_valid_r && (s1_idx_r == $past(s1_idx_r)))
    |-> (cur_count == '0))
    else $error("count of a closed frame not cleared for the next cell");

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
    else $error("result queue overrun");

  a_no_cell_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |=> !s1_valid_r)
    else $error("cell accepted during clearing pass");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_result && ok) |=> (total_r == $past(total_r)))
    else $error("delivery total moved without a delivered frame");

endmodule
